### rtl/akf_pkg.sv
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types and constants for the two-state angle Kalman filter.
// ----------------------------------------------------------------------------
package akf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int DT_FRAC  = 16;
    localparam int COV_FRAC = 24;

    localparam logic [31:0] RESET_QA = 32'd16777;
    localparam logic [31:0] RESET_QB = 32'd50332;
    localparam logic [31:0] RESET_R  = 32'd503316;

    localparam logic [1:0] REG_QA    = 2'd0;
    localparam logic [1:0] REG_QB    = 2'd1;
    localparam logic [1:0] REG_R     = 2'd2;
    localparam logic [1:0] REG_ANGLE = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_ANG,
        ST_D,
        ST_P00,
        ST_PB,
        ST_DIV0,
        ST_DIV1,
        ST_Y,
        ST_KA,
        ST_KB,
        ST_C00,
        ST_C01,
        ST_C10,
        ST_C11,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            sat32 = 32'h7fffffff;
        else if (v < -66'sd2147483648)
            sat32 = 32'h80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

### rtl/akf_mul.sv
// ----------------------------------------------------------------------------
// akf_mul
// Bit-serial signed multiplier with rounded shift, 35 x 35 bits, one bit a cycle.
// ----------------------------------------------------------------------------
module akf_mul
    import akf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [34:0] a,
    input  logic signed [34:0] b,
    input  logic [4:0]         shift,
    output logic               done,
    output logic signed [65:0] result
);

    logic [34:0] mag_a_reg, mag_a_next;
    logic [34:0] mag_b_reg, mag_b_next;
    logic [69:0] acc_reg, acc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [69:0] rounded;

    always_comb
    begin
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            mag_a_next = a[34] ? 35'(-a) : a;
            mag_b_next = b[34] ? 35'(-b) : b;
            neg_next   = a[34] ^ b[34];
            acc_next   = '0;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            if (mag_b_reg[0])
                acc_next = acc_reg + (70'(mag_a_reg) << cnt_reg);
            mag_b_next = mag_b_reg >> 1;
            cnt_next   = cnt_reg + 6'd1;
            if (cnt_reg == 6'd34)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
    end

    assign rounded = (shift == 5'd0) ? acc_reg :
                     ((acc_reg + (70'd1 << (shift - 5'd1))) >> shift);
    assign done    = done_reg;
    assign result  = neg_reg ? 66'(-$signed({1'b0, rounded[64:0]}))
                             : $signed({1'b0, rounded[64:0]});

endmodule

### rtl/akf_div.sv
// ----------------------------------------------------------------------------
// akf_div
// Restoring signed divider, 56-bit dividend over 34-bit divisor, one bit a cycle.
// Quotient truncates toward zero and saturates to 32 bits.
// ----------------------------------------------------------------------------
module akf_div
    import akf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctl_t           ctl,
    input  logic signed [31:0] num,
    input  logic signed [33:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic [55:0] n_reg, n_next;
    logic [33:0] d_reg, d_next;
    logic [34:0] r_reg, r_next;
    logic [55:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [34:0] trial;
    logic [34:0] rsh;

    assign rsh   = {r_reg[33:0], n_reg[55]};
    assign trial = rsh - {1'b0, d_reg};

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            n_next   = {(num[31] ? 32'(-num) : num), 24'd0};
            d_next   = den[33] ? 34'(-den) : den;
            neg_next = num[31] ^ den[33];
            r_next   = '0;
            q_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            n_next = n_reg << 1;
            if (!trial[34])
            begin
                r_next = trial;
                q_next = {q_reg[54:0], 1'b1};
            end
            else
            begin
                r_next = rsh;
                q_next = {q_reg[54:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd55)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = (d_reg == '0) ? 32'sd0 :
                  sat32(neg_reg ? -$signed({10'd0, q_reg}) : $signed({10'd0, q_reg}));

endmodule

### rtl/angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_kalman_filter
// Two-state Kalman filter: tilt angle and gyro bias from angle and rate.
// ----------------------------------------------------------------------------
// One item at a time. The next item is accepted only once the last is through:
// ten products on a bit-serial multiplier and two quotients on a bit-serial
// divider, run in sequence by the controller, plus the idle, rate, innovation
// and output control states. The result waits in an output register while
// the next item is taken; a new result waits until the previous one has gone.
module angle_kalman_filter
    import akf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] gyro_rate,
    input  logic [15:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_angle,
    output logic signed [31:0] corrected_rate,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    state_t state_reg, state_next;
    logic [31:0]        qa_reg, qb_reg, r_reg;
    logic signed [31:0] ang_reg, bias_reg, rate_reg, last_rate_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] meas_reg, gyro_reg, y_reg, k0_reg, k1_reg;
    logic signed [31:0] p00o_reg, p01o_reg, d_reg;
    logic [15:0]        dt_reg;
    logic               out_valid_reg;
    logic signed [31:0] fa_reg, cr_reg;

    logic               mstart, mdone;
    logic signed [34:0] ma, mb;
    logic [4:0]         msh;
    logic signed [65:0] mres;
    div_ctl_t           dctl;
    logic               ddone;
    logic signed [31:0] dnum, dquot;
    logic signed [33:0] sden;
    logic               step_wait;
    logic               out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign sden      = 34'(p00_reg) + 34'($signed({1'b0, r_reg}));
    assign step_wait = (state_reg == ST_DIV0 || state_reg == ST_DIV1) ? !ddone : !mdone;

    akf_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .shift(msh),
                   .done(mdone), .result(mres));
    akf_div u_div (.clk, .rst_n, .ctl(dctl), .num(dnum), .den(sden),
                   .done(ddone), .quot(dquot));

    logic started_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid && in_ready) state_next = ST_RATE;
            ST_RATE:  state_next = ST_ANG;
            ST_Y:     state_next = ST_KA;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  if (started_reg && !step_wait)
                          state_next = state_t'(state_reg + 5'd1);
        endcase
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        msh = 5'(DT_FRAC);
        dnum = p00_reg;
        case (state_reg)
            ST_ANG: begin ma = 35'($signed({1'b0, dt_reg})); mb = 35'(rate_reg); end
            ST_D:   begin ma = 35'($signed({1'b0, dt_reg})); mb = 35'(p11_reg); end
            ST_P00:
            begin
                ma = 35'($signed({1'b0, dt_reg}));
                mb = 35'(d_reg) - 35'(p01_reg) - 35'(p10_reg) + 35'($signed({1'b0, qa_reg}));
            end
            ST_PB:  begin ma = 35'($signed({1'b0, dt_reg})); mb = 35'($signed({1'b0, qb_reg})); end
            ST_KA:  begin ma = 35'(k0_reg); mb = 35'(y_reg); msh = 5'(COV_FRAC); end
            ST_KB:  begin ma = 35'(k1_reg); mb = 35'(y_reg); msh = 5'(COV_FRAC); end
            ST_C00: begin ma = 35'(k0_reg); mb = 35'(p00o_reg); msh = 5'(COV_FRAC); end
            ST_C01: begin ma = 35'(k0_reg); mb = 35'(p01o_reg); msh = 5'(COV_FRAC); end
            ST_C10: begin ma = 35'(k1_reg); mb = 35'(p00o_reg); msh = 5'(COV_FRAC); end
            ST_C11: begin ma = 35'(k1_reg); mb = 35'(p01o_reg); msh = 5'(COV_FRAC); end
            ST_DIV1: dnum = p10_reg;
            default: ;
        endcase
        mstart     = !started_reg && !(state_reg == ST_IDLE || state_reg == ST_RATE
                     || state_reg == ST_OUT || state_reg == ST_DIV0 || state_reg == ST_DIV1
                     || state_reg == ST_Y);
        dctl.start = !started_reg && (state_reg == ST_DIV0 || state_reg == ST_DIV1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            qa_reg        <= RESET_QA;
            qb_reg        <= RESET_QB;
            r_reg         <= RESET_R;
            ang_reg       <= '0;
            bias_reg      <= '0;
            last_rate_reg <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                started_reg <= 1'b0;
            else if (mstart || dctl.start)
                started_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QA:    qa_reg <= cfg_data;
                    REG_QB:    qb_reg <= cfg_data;
                    REG_R:     r_reg  <= cfg_data;
                    REG_ANGLE: ang_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_RATE:
                begin
                    rate_reg      <= sat32(66'(gyro_reg) - 66'(bias_reg));
                    last_rate_reg <= sat32(66'(gyro_reg) - 66'(bias_reg));
                end
                default: ;
            endcase
            if (started_reg && !step_wait)
            begin
                case (state_reg)
                    ST_ANG:  ang_reg <= sat32(66'(ang_reg) + mres);
                    ST_D:    d_reg <= mres[31:0];
                    ST_P00:
                    begin
                        p00_reg <= sat32(66'(p00_reg) + mres);
                        p01_reg <= sat32(66'(p01_reg) - 66'(d_reg));
                        p10_reg <= sat32(66'(p10_reg) - 66'(d_reg));
                    end
                    ST_PB:   p11_reg <= sat32(66'(p11_reg) + mres);
                    ST_DIV0:
                    begin
                        k0_reg   <= dquot;
                        p00o_reg <= p00_reg;
                        p01o_reg <= p01_reg;
                    end
                    ST_DIV1: k1_reg <= dquot;
                    ST_KA:   ang_reg <= sat32(66'(ang_reg) + mres);
                    ST_KB:   bias_reg <= sat32(66'(bias_reg) + mres);
                    ST_C00:  p00_reg <= sat32(66'(p00_reg) - mres);
                    ST_C01:  p01_reg <= sat32(66'(p01_reg) - mres);
                    ST_C10:  p10_reg <= sat32(66'(p10_reg) - mres);
                    ST_C11:  p11_reg <= sat32(66'(p11_reg) - mres);
                    default: ;
                endcase
            end
            if (state_reg == ST_Y)
                y_reg <= sat32(66'(meas_reg) - 66'(ang_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg <= measured_angle;
            gyro_reg <= gyro_rate;
            dt_reg   <= time_step;
        end
        if (out_load)
        begin
            fa_reg <= ang_reg;
            cr_reg <= last_rate_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_angle = fa_reg;
    assign corrected_rate = cr_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("result not shown after finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(filtered_angle) && $stable(corrected_rate)))
        else $error("waiting result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mstart && dctl.start))
        else $error("multiplier and divider started together");

endmodule
